FILE: sv/vaq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaq_pkg
// Shared types, constants and float32 helpers of the vertex attribute
// quantizer.
// ----------------------------------------------------------------------------
package vaq_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MASK      = 3'd0,
    CFG_MIN_X     = 3'd1,
    CFG_MIN_Y     = 3'd2,
    CFG_MIN_Z     = 3'd3,
    CFG_INV_X     = 3'd4,
    CFG_INV_Y     = 3'd5,
    CFG_INV_Z     = 3'd6
  } cfg_reg_e;

  // Bits of the component mask.
  localparam int unsigned MASK_POS = 0;
  localparam int unsigned MASK_NRM = 1;
  localparam int unsigned MASK_UV0 = 2;
  localparam int unsigned MASK_UV1 = 3;
  localparam int unsigned MASK_TAN = 4;

  localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FP_65535 = 32'h477F_FF00;
  localparam logic [31:0] FP_32767 = 32'h46FF_FE00;
  localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;
  localparam logic [30:0] FP_INF   = 31'h7F80_0000;

  // Pipeline depths of the arithmetic units.
  localparam int unsigned FSUB_LAT  = 4;
  localparam int unsigned FMUL_LAT  = 4;
  localparam int unsigned UNORM_LAT = FSUB_LAT + 2 * FMUL_LAT + 2;
  localparam int unsigned SNORM_LAT = FMUL_LAT + 1;

  // Operand class carried next to the datapath.
  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sign;
  } fp_cls_t;

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] f);
    return f[30:0] == 31'd0;
  endfunction

  // Leading zero count; an all-zero word gives 48.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       done;
    n    = 6'd48;
    done = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!done && v[i]) begin
        n    = 6'(47 - i);
        done = 1'b1;
      end
    end
    return n;
  endfunction

  // Magnitude of a float rounded half away from zero, saturated to 17 bits.
  function automatic logic [16:0] round_mag(input logic [31:0] f);
    logic [7:0]  e;
    logic [23:0] m;
    logic [4:0]  k;
    logic [23:0] t;
    logic [24:0] r;
    e = f[30:23];
    m = {1'b1, f[22:0]};
    k = 5'd0;
    t = 24'd0;
    r = 25'd0;
    if (e < 8'd126) begin
      r = 25'd0;
    end else if (e >= 8'd143) begin
      r = 25'h1_FFFF;
    end else begin
      k = 5'(8'd149 - e);
      t = m >> k;
      r = (25'(t) + 25'd1) >> 1;
    end
    return r[16:0];
  endfunction

endpackage

FILE: sv/vertex_attribute_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_attribute_quantizer
// Packs one vertex of float32 attributes per word into 16-bit unorm
// positions, 16-bit snorm normals and tangents, and half-float UVs.
// ----------------------------------------------------------------------------
// The block takes one vertex word in every clock cycle while not stalled; the
// pipeline depth is set by the position path, which runs a
// float32 subtract and a multiply by the inverse extent (four stages each), a
// one-stage clamp, a multiply by 65535 (four stages) and a one-stage rounding
// step. Normal, tangent and
// UV results are delay-matched to it, so words leave in the order they came.
// All stages move together: when the output word is held by the consumer the
// whole pipeline stops, and in_ready_o then follows out_ready_i in the same
// cycle; while the output register is empty or being taken, input is taken
// every cycle. Arithmetic is IEEE single precision with round to nearest even,
// subnormals included. A NaN position or scaled normal or tangent gives zero;
// components switched off in the component mask read as zero. Registers are
// written through the configuration port, which is always ready, and should
// only be changed while no vertex is in flight. There is no start-up sweep.
// ----------------------------------------------------------------------------
module vertex_attribute_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Vertex input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] pos_xy_i,
  input  logic [31:0] pos_z_i,
  input  logic [63:0] normal_xy_i,
  input  logic [31:0] normal_z_i,
  input  logic [63:0] uv_first_i,
  input  logic [63:0] uv_second_i,
  input  logic [63:0] tangent_xy_i,
  input  logic [63:0] tangent_zw_i,
  input  logic        last_vertex_i,
  // Packed output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] pos_packed_o,
  output logic [47:0] normal_packed_o,
  output logic [31:0] uv_first_half_o,
  output logic [31:0] uv_second_half_o,
  output logic [63:0] tangent_packed_o,
  output logic        last_out_o
);

  localparam int unsigned DEPTH  = vaq_pkg::UNORM_LAT;
  localparam int unsigned SN_DLY = vaq_pkg::UNORM_LAT - vaq_pkg::SNORM_LAT;

  // Float32 to half, round to nearest even; NaNs keep sign and top payload.
  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic        s;
    logic [7:0]  ex;
    logic [23:0] m, rem, hw;
    logic [4:0]  sh;
    logic [14:0] h;
    logic        fin;
    logic [15:0] r;
    s   = b[31];
    ex  = b[30:23];
    m   = {1'b1, b[22:0]};
    sh  = 5'd0;
    rem = 24'd0;
    hw  = 24'd0;
    h   = 15'd0;
    fin = 1'b0;
    r   = 16'd0;
    if (ex == 8'hFF) begin
      r = (b[22:0] != 23'd0) ? {s, 5'h1F, 10'h200 | b[22:13]} : {s, 15'h7C00};
    end else if (ex >= 8'd143) begin
      r = {s, 15'h7C00};
    end else if (ex < 8'd102) begin
      r = {s, 15'd0};
    end else if (ex <= 8'd112) begin
      sh  = 5'(8'd126 - ex);
      h   = 15'(m >> sh);
      rem = m & ~(24'hFF_FFFF << sh);
      hw  = 24'd1 << (sh - 5'd1);
      fin = 1'b1;
    end else begin
      h   = {5'(ex - 8'd112), b[22:13]};
      rem = {11'd0, b[12:0]};
      hw  = 24'h00_1000;
      fin = 1'b1;
    end
    if (fin) begin
      if ((rem > hw) || ((rem == hw) && h[0])) begin
        h = h + 15'd1;
      end
      r = {s, h};
    end
    return r;
  endfunction

  // Configuration registers.
  logic [4:0]       mask_q;
  logic [2:0][31:0] min_q, inv_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 5'h1F;
      min_q  <= '0;
      inv_q  <= '0;
    end else if (cfg_valid_i) begin
      case (vaq_pkg::cfg_reg_e'(cfg_index_i))
        vaq_pkg::CFG_MASK:  mask_q   <= cfg_data_i[4:0];
        vaq_pkg::CFG_MIN_X: min_q[0] <= cfg_data_i;
        vaq_pkg::CFG_MIN_Y: min_q[1] <= cfg_data_i;
        vaq_pkg::CFG_MIN_Z: min_q[2] <= cfg_data_i;
        vaq_pkg::CFG_INV_X: inv_q[0] <= cfg_data_i;
        vaq_pkg::CFG_INV_Y: inv_q[1] <= cfg_data_i;
        vaq_pkg::CFG_INV_Z: inv_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless a finished word is held.
  logic             adv;
  logic [DEPTH-1:0] vld_q;

  assign adv         = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Position: three axis quantizers.
  logic [2:0][31:0] pos_in;
  logic [2:0][15:0] pos_q;

  assign pos_in = {pos_z_i, pos_xy_i};

  for (genvar i = 0; i < 3; i++) begin : g_pos
    vaq_unorm u_unorm (
      .clk_i (clk_i),
      .en_i  (adv),
      .p_i   (pos_in[i]),
      .min_i (min_q[i]),
      .inv_i (inv_q[i]),
      .q_o   (pos_q[i])
    );
  end

  // Normal x..z then tangent x..w.
  logic [6:0][31:0]          sn_in;
  logic [6:0][15:0]          sn_out;
  logic [SN_DLY-1:0][111:0]  snd_q;

  assign sn_in = {tangent_zw_i, tangent_xy_i, normal_z_i, normal_xy_i};

  for (genvar i = 0; i < 7; i++) begin : g_snorm
    vaq_snorm u_snorm (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (sn_in[i]),
      .q_o   (sn_out[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      snd_q <= {snd_q[SN_DLY-2:0], sn_out};
    end
  end

  // UV halves and the batch marker ride a plain delay line.
  logic [64:0]             hd_d;
  logic [DEPTH-1:0][64:0]  hd_q;

  assign hd_d = {last_vertex_i,
                 to_half(uv_second_i[63:32]), to_half(uv_second_i[31:0]),
                 to_half(uv_first_i[63:32]), to_half(uv_first_i[31:0])};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hd_q <= {hd_q[DEPTH-2:0], hd_d};
    end
  end

  // Output word with disabled components forced to zero.
  assign pos_packed_o     = mask_q[vaq_pkg::MASK_POS] ? pos_q : 48'd0;
  assign normal_packed_o  = mask_q[vaq_pkg::MASK_NRM] ? snd_q[SN_DLY-1][47:0] : 48'd0;
  assign tangent_packed_o = mask_q[vaq_pkg::MASK_TAN] ? snd_q[SN_DLY-1][111:48] : 64'd0;
  assign uv_first_half_o  = mask_q[vaq_pkg::MASK_UV0] ? hd_q[DEPTH-1][31:0] : 32'd0;
  assign uv_second_half_o = mask_q[vaq_pkg::MASK_UV1] ? hd_q[DEPTH-1][63:32] : 32'd0;
  assign last_out_o       = hd_q[DEPTH-1][64];

`ifndef NO_ASSERTIONS
  // An empty output register must never hold back the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register is empty");

  // An accepted word enters the first pipeline stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  // A stalled pipeline keeps every valid bit in place.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("valid bits moved during a stall");
`endif

endmodule

FILE: sv/vaq_fsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaq_fsub
// Four-stage float32 subtractor y = a - b, round to nearest even, with
// subnormal support.
// ----------------------------------------------------------------------------
module vaq_fsub (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  // Stage 1: classify, order by magnitude.
  vaq_pkg::fp_cls_t s1_cls_d, s1_cls_q;
  logic             s1_sub_d, s1_sub_q;
  logic [7:0]       s1_e_d, s1_e_q, s1_dist_d, s1_dist_q;
  logic [23:0]      s1_mb_d, s1_mb_q, s1_ms_d, s1_ms_q;

  always_comb begin
    logic [31:0] bn;
    logic [7:0]  ea, eb;
    logic        a_big;
    bn    = {~b_i[31], b_i[30:0]};
    ea    = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb    = (bn[30:23] == 8'd0) ? 8'd1 : bn[30:23];
    a_big = a_i[30:0] >= bn[30:0];
    s1_cls_d.nan  = vaq_pkg::is_nan(a_i) || vaq_pkg::is_nan(bn) ||
                    (vaq_pkg::is_inf(a_i) && vaq_pkg::is_inf(bn) && (a_i[31] != bn[31]));
    s1_cls_d.inf  = vaq_pkg::is_inf(a_i) || vaq_pkg::is_inf(bn);
    s1_cls_d.zero = vaq_pkg::is_zero(a_i) && vaq_pkg::is_zero(bn) && a_i[31] && bn[31];
    s1_cls_d.sign = a_big ? a_i[31] : bn[31];
    s1_sub_d  = a_i[31] != bn[31];
    s1_e_d    = a_big ? ea : eb;
    s1_dist_d = a_big ? (ea - eb) : (eb - ea);
    s1_mb_d   = a_big ? {a_i[30:23] != 8'd0, a_i[22:0]} : {bn[30:23] != 8'd0, bn[22:0]};
    s1_ms_d   = a_big ? {bn[30:23] != 8'd0, bn[22:0]} : {a_i[30:23] != 8'd0, a_i[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cls_q  <= s1_cls_d;
      s1_sub_q  <= s1_sub_d;
      s1_e_q    <= s1_e_d;
      s1_dist_q <= s1_dist_d;
      s1_mb_q   <= s1_mb_d;
      s1_ms_q   <= s1_ms_d;
    end
  end

  // Stage 2: align the smaller operand with guard, round and sticky bits.
  vaq_pkg::fp_cls_t s2_cls_q;
  logic [7:0]       s2_e_q;
  logic [27:0]      s2_r_d, s2_r_q;

  always_comb begin
    logic [26:0] ext, shd, al;
    logic        stk;
    ext = {s1_ms_q, 3'b000};
    shd = ext >> s1_dist_q;
    stk = |(ext & ~({27{1'b1}} << s1_dist_q));
    if (s1_dist_q >= 8'd27) begin
      al = {26'd0, |s1_ms_q};
    end else begin
      al = {shd[26:1], shd[0] | stk};
    end
    if (s1_sub_q) begin
      s2_r_d = {1'b0, s1_mb_q, 3'b000} - {1'b0, al};
    end else begin
      s2_r_d = {1'b0, s1_mb_q, 3'b000} + {1'b0, al};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_cls_q <= s1_cls_q;
      s2_e_q   <= s1_e_q;
      s2_r_q   <= s2_r_d;
    end
  end

  // Stage 3: normalize, never below the smallest normal exponent.
  vaq_pkg::fp_cls_t s3_cls_q;
  logic [26:0]      s3_m_d, s3_m_q;
  logic [8:0]       s3_e_d, s3_e_q;
  logic             s3_z_d, s3_z_q;

  always_comb begin
    logic [5:0] lz;
    logic [7:0] lim, s;
    lz  = vaq_pkg::lzc48({s2_r_q[26:0], 21'd0});
    lim = s2_e_q - 8'd1;
    s   = ({2'b00, lz} > lim) ? lim : {2'b00, lz};
    s3_z_d = s2_r_q == 28'd0;
    if (s2_r_q[27]) begin
      s3_m_d = {s2_r_q[27:2], s2_r_q[1] | s2_r_q[0]};
      s3_e_d = {1'b0, s2_e_q} + 9'd1;
    end else begin
      s3_m_d = s2_r_q[26:0] << s;
      s3_e_d = {1'b0, s2_e_q} - {1'b0, s};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_cls_q <= s2_cls_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_m_q <= s3_m_d;
      s3_e_q <= s3_e_d;
      s3_z_q <= s3_z_d;
    end
  end

  // Stage 4: round to nearest even and pack.
  logic [31:0] y_d, y_q;

  always_comb begin
    logic [7:0]  ef;
    logic        rnd;
    logic [30:0] sum;
    rnd = s3_m_q[2] & (s3_m_q[1] | s3_m_q[0] | s3_m_q[3]);
    ef  = s3_m_q[26] ? s3_e_q[7:0] : 8'd0;
    sum = {ef, s3_m_q[25:3]} + 31'(rnd);
    if (s3_cls_q.nan) begin
      y_d = vaq_pkg::FP_QNAN;
    end else if (s3_cls_q.inf || (s3_e_q >= 9'd255)) begin
      y_d = {s3_cls_q.sign, vaq_pkg::FP_INF};
    end else if (s3_z_q) begin
      y_d = {s3_cls_q.zero, 31'd0};
    end else begin
      y_d = {s3_cls_q.sign, sum};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

FILE: sv/vaq_fmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaq_fmul
// Four-stage float32 multiplier, round to nearest even, with subnormal
// support.
// ----------------------------------------------------------------------------
module vaq_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  // Stage 1: classify and multiply the significands.
  vaq_pkg::fp_cls_t   s1_cls_d, s1_cls_q;
  logic [47:0]        s1_p_d, s1_p_q;
  logic signed [10:0] s1_t_d, s1_t_q;

  always_comb begin
    logic [7:0] ea, eb;
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    s1_cls_d.nan  = vaq_pkg::is_nan(a_i) || vaq_pkg::is_nan(b_i) ||
                    (vaq_pkg::is_inf(a_i) && vaq_pkg::is_zero(b_i)) ||
                    (vaq_pkg::is_inf(b_i) && vaq_pkg::is_zero(a_i));
    s1_cls_d.inf  = vaq_pkg::is_inf(a_i) || vaq_pkg::is_inf(b_i);
    s1_cls_d.zero = vaq_pkg::is_zero(a_i) || vaq_pkg::is_zero(b_i);
    s1_cls_d.sign = a_i[31] ^ b_i[31];
    s1_p_d = {a_i[30:23] != 8'd0, a_i[22:0]} * {b_i[30:23] != 8'd0, b_i[22:0]};
    s1_t_d = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cls_q <= s1_cls_d;
      s1_p_q   <= s1_p_d;
      s1_t_q   <= s1_t_d;
    end
  end

  // Stage 2: leading zero count and shift plan.
  vaq_pkg::fp_cls_t s2_cls_q;
  logic [47:0]      s2_p_q;
  logic             s2_left_d, s2_left_q;
  logic [5:0]       s2_sh_d, s2_sh_q;
  logic [8:0]       s2_e_d, s2_e_q;

  always_comb begin
    logic [5:0]         lz;
    logic signed [10:0] diff, rsh;
    lz   = vaq_pkg::lzc48(s1_p_q);
    diff = s1_t_q - $signed({5'd0, lz});
    rsh  = 11'sd1 - s1_t_q;
    if (diff >= 11'sd1) begin
      s2_left_d = 1'b1;
      s2_sh_d   = lz;
      s2_e_d    = diff[8:0];
    end else if (s1_t_q >= 11'sd1) begin
      s2_left_d = 1'b1;
      s2_sh_d   = s1_t_q[5:0] - 6'd1;
      s2_e_d    = 9'd0;
    end else begin
      s2_left_d = 1'b0;
      s2_sh_d   = (rsh > 11'sd48) ? 6'd48 : rsh[5:0];
      s2_e_d    = 9'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_cls_q  <= s1_cls_q;
      s2_p_q    <= s1_p_q;
      s2_left_q <= s2_left_d;
      s2_sh_q   <= s2_sh_d;
      s2_e_q    <= s2_e_d;
    end
  end

  // Stage 3: shift into place and collect guard and sticky.
  vaq_pkg::fp_cls_t s3_cls_q;
  logic [23:0]      s3_m_d, s3_m_q;
  logic             s3_g_d, s3_g_q, s3_st_d, s3_st_q;
  logic [8:0]       s3_e_q;

  always_comb begin
    logic [47:0] q;
    logic        lost;
    if (s2_left_q) begin
      q    = s2_p_q << s2_sh_q;
      lost = 1'b0;
    end else begin
      q    = s2_p_q >> s2_sh_q;
      lost = |(s2_p_q & ~({48{1'b1}} << s2_sh_q));
    end
    s3_m_d  = q[47:24];
    s3_g_d  = q[23];
    s3_st_d = (|q[22:0]) | lost;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_cls_q <= s2_cls_q;
      s3_m_q   <= s3_m_d;
      s3_g_q   <= s3_g_d;
      s3_st_q  <= s3_st_d;
      s3_e_q   <= s2_e_q;
    end
  end

  // Stage 4: round to nearest even and pack.
  logic [31:0] y_d, y_q;

  always_comb begin
    logic [7:0]  ef;
    logic        rnd;
    logic [30:0] sum;
    rnd = s3_g_q & (s3_st_q | s3_m_q[0]);
    ef  = s3_m_q[23] ? s3_e_q[7:0] : 8'd0;
    sum = {ef, s3_m_q[22:0]} + 31'(rnd);
    if (s3_cls_q.nan) begin
      y_d = vaq_pkg::FP_QNAN;
    end else if (s3_cls_q.inf) begin
      y_d = {s3_cls_q.sign, vaq_pkg::FP_INF};
    end else if (s3_cls_q.zero) begin
      y_d = {s3_cls_q.sign, 31'd0};
    end else if (s3_e_q >= 9'd255) begin
      y_d = {s3_cls_q.sign, vaq_pkg::FP_INF};
    end else begin
      y_d = {s3_cls_q.sign, sum};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

FILE: sv/vaq_snorm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaq_snorm
// Signed normalized 16-bit quantizer: scale by 32767, round half away from
// zero, saturate.
// ----------------------------------------------------------------------------
module vaq_snorm (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  output logic [15:0] q_o
);

  logic [31:0] v;
  logic [15:0] q_d, q_q;

  vaq_fmul u_mul (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (x_i),
    .b_i   (vaq_pkg::FP_32767),
    .y_o   (v)
  );

  always_comb begin
    logic [16:0] mag;
    mag = vaq_pkg::round_mag(v);
    if (vaq_pkg::is_nan(v)) begin
      q_d = 16'd0;
    end else if (v[31]) begin
      q_d = (mag > 17'd32768) ? 16'h8000 : (16'd0 - mag[15:0]);
    end else begin
      q_d = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

FILE: sv/vaq_unorm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaq_unorm
// Position axis quantizer: offset, scale, clamp to 0..1, scale by 65535 and
// round half away from zero to 16 bits.
// ----------------------------------------------------------------------------
module vaq_unorm (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] p_i,
  input  logic [31:0] min_i,
  input  logic [31:0] inv_i,
  output logic [15:0] q_o
);

  logic [31:0] diff, scaled, wide;
  logic [31:0] clamp_d, clamp_q;
  logic [15:0] q_d, q_q;

  vaq_fsub u_sub (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (p_i),
    .b_i   (min_i),
    .y_o   (diff)
  );

  vaq_fmul u_scale (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (diff),
    .b_i   (inv_i),
    .y_o   (scaled)
  );

  // NaN and negative values go to zero, anything above one to one.
  always_comb begin
    if (vaq_pkg::is_nan(scaled) || scaled[31]) begin
      clamp_d = 32'd0;
    end else if (scaled[30:0] > vaq_pkg::FP_ONE[30:0]) begin
      clamp_d = vaq_pkg::FP_ONE;
    end else begin
      clamp_d = scaled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clamp_q <= clamp_d;
    end
  end

  vaq_fmul u_range (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (clamp_q),
    .b_i   (vaq_pkg::FP_65535),
    .y_o   (wide)
  );

  always_comb begin
    logic [16:0] mag;
    mag = vaq_pkg::round_mag(wide);
    q_d = (mag > 17'd65535) ? 16'hFFFF : mag[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

FILE: tb/vertex_attribute_quantizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_attribute_quantizer_test
// Self-checking regression of the vertex attribute quantizer: directed corner
// vertices, register sweeps and random vertex streams under input and output
// stalls, each packed word checked against a float32 model of the block.
// ----------------------------------------------------------------------------
module vertex_attribute_quantizer_test;

  // One vertex word as it enters the block.
  typedef struct packed {
    logic [63:0] pos_xy;
    logic [31:0] pos_z;
    logic [63:0] normal_xy;
    logic [31:0] normal_z;
    logic [63:0] uv_first;
    logic [63:0] uv_second;
    logic [63:0] tangent_xy;
    logic [63:0] tangent_zw;
    logic        last_vertex;
  } vertex_t;

  // One packed word as it leaves the block.
  typedef struct packed {
    logic [47:0] pos;
    logic [47:0] nrm;
    logic [31:0] uv0;
    logic [31:0] uv1;
    logic [63:0] tan;
    logic        last;
  } packed_vertex_t;

  localparam logic [31:0] F32_NAN_NEG = 32'hFFC0_0001;
  localparam logic [31:0] F32_PINF    = 32'h7F80_0000;
  localparam logic [31:0] F32_NINF    = 32'hFF80_0000;
  localparam logic [31:0] F32_MAX     = 32'h7F7F_FFFF;
  localparam logic [31:0] F32_MINUS1  = 32'hBF80_0000;
  localparam logic [31:0] F32_HALF    = 32'h3F00_0000;
  localparam logic [31:0] F32_DENORM  = 32'h0000_0001;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] pos_xy_i;
  logic [31:0] pos_z_i;
  logic [63:0] normal_xy_i;
  logic [31:0] normal_z_i;
  logic [63:0] uv_first_i;
  logic [63:0] uv_second_i;
  logic [63:0] tangent_xy_i;
  logic [63:0] tangent_zw_i;
  logic        last_vertex_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [47:0] pos_packed_o;
  logic [47:0] normal_packed_o;
  logic [31:0] uv_first_half_o;
  logic [31:0] uv_second_half_o;
  logic [63:0] tangent_packed_o;
  logic        last_out_o;

  vertex_attribute_quantizer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pos_xy_i        (pos_xy_i),
    .pos_z_i         (pos_z_i),
    .normal_xy_i     (normal_xy_i),
    .normal_z_i      (normal_z_i),
    .uv_first_i      (uv_first_i),
    .uv_second_i     (uv_second_i),
    .tangent_xy_i    (tangent_xy_i),
    .tangent_zw_i    (tangent_zw_i),
    .last_vertex_i   (last_vertex_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pos_packed_o    (pos_packed_o),
    .normal_packed_o (normal_packed_o),
    .uv_first_half_o (uv_first_half_o),
    .uv_second_half_o(uv_second_half_o),
    .tangent_packed_o(tangent_packed_o),
    .last_out_o      (last_out_o)
  );

  // Shadow copy of the configuration registers, starting at the reset values.
  logic [4:0]  mask_q = 5'd31;
  logic [31:0] min_q [3] = '{32'd0, 32'd0, 32'd0};
  logic [31:0] inv_q [3] = '{32'd0, 32'd0, 32'd0};

  packed_vertex_t packed_words_due[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_cycles = 0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // --------------------------------------------------------------------------
  // Float32 model. Finite operands go through double precision and are then
  // rounded once to single precision; double carries more than twice the
  // single mantissa, so add, subtract and multiply come out correctly rounded.
  // NaN and infinity are handled on the bit patterns.
  // --------------------------------------------------------------------------
  function automatic real f32_to_real(input logic [31:0] f);
    logic [63:0] d;
    real         scale;
    if (f[30:23] == 8'd0) begin
      // Subnormal: mantissa times two to the minus 149.
      scale = $bitstoreal({1'b0, 11'(1023 - 149), 52'd0});
      return (f[31] ? -1.0 : 1.0) * real'(f[22:0]) * scale;
    end
    d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
    return $bitstoreal(d);
  endfunction

  // Round a finite double to the nearest float32, ties to even.
  function automatic logic [31:0] real_to_f32(input real x);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] h;
    logic [63:0] rem;
    logic [63:0] halfway;
    logic [63:0] bits;
    int          exp_f;
    int          sh;
    d = $realtobits(x);
    if (d[62:0] == 63'd0) return {d[63], 31'd0};
    exp_f = int'(d[62:52]) - 1023 + 127;
    if (exp_f >= 255) return {d[63], F32_PINF[30:0]};
    m  = {11'd0, 1'b1, d[51:0]};
    sh = (exp_f >= 1) ? 29 : 29 + 1 - exp_f;
    if (sh > 54) return {d[63], 31'd0};
    h       = m >> sh;
    rem     = m & ((64'd1 << sh) - 64'd1);
    halfway = 64'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && h[0])) h = h + 64'd1;
    // A normal value keeps its hidden bit in h; the carry bumps the exponent.
    bits = (exp_f >= 1) ? ((64'(exp_f - 1) << 23) + h) : h;
    if (bits >= 64'h7F80_0000) return {d[63], F32_PINF[30:0]};
    return {d[63], bits[30:0]};
  endfunction

  function automatic logic f32_nan(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != 23'd0;
  endfunction

  function automatic logic f32_inf(input logic [31:0] f);
    return f[30:0] == F32_PINF[30:0];
  endfunction

  function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] b);
    if (f32_nan(a) || f32_nan(b)) return vaq_pkg::FP_QNAN;
    if (f32_inf(a) && f32_inf(b)) return (a[31] == b[31]) ? vaq_pkg::FP_QNAN : a;
    if (f32_inf(a)) return a;
    if (f32_inf(b)) return {~b[31], b[30:0]};
    return real_to_f32(f32_to_real(a) - f32_to_real(b));
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (f32_nan(a) || f32_nan(b)) return vaq_pkg::FP_QNAN;
    if (f32_inf(a) || f32_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return vaq_pkg::FP_QNAN;
      return {s, F32_PINF[30:0]};
    end
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  // Magnitude rounded half away from zero and capped.
  function automatic logic [16:0] round_half_away(input logic [31:0] f, input int cap);
    real r;
    if (f32_inf(f)) return 17'(cap);
    r = f32_to_real({1'b0, f[30:0]}) + 0.5;
    if (r >= real'(cap)) return 17'(cap);
    return 17'($rtoi(r));
  endfunction

  function automatic logic [15:0] unorm16(input logic [31:0] p, input logic [31:0] lo,
                                          input logic [31:0] inv);
    logic [31:0] v;
    v = f32_mul(f32_sub(p, lo), inv);
    if (f32_nan(v)) return 16'd0;
    if (v[31]) v = 32'd0;
    else if (v > vaq_pkg::FP_ONE) v = vaq_pkg::FP_ONE;
    return 16'(round_half_away(f32_mul(v, vaq_pkg::FP_65535), 65535));
  endfunction

  function automatic logic [15:0] snorm16(input logic [31:0] f);
    logic [31:0] v;
    logic [16:0] m;
    v = f32_mul(f, vaq_pkg::FP_32767);
    if (f32_nan(v)) return 16'd0;
    if (v[31]) begin
      m = round_half_away(v, 32768);
      return 16'(17'h1_0000 - m);
    end
    return 16'(round_half_away(v, 32767));
  endfunction

  function automatic logic [15:0] half_of(input logic [31:0] b);
    logic [15:0] sgn;
    logic [22:0] man;
    logic [31:0] m;
    logic [31:0] h;
    logic [31:0] rem;
    logic [31:0] halfway;
    int          e;
    int          sh;
    sgn = {b[31], 15'd0};
    man = b[22:0];
    if (b[30:23] == 8'hFF) begin
      if (man != 23'd0) return sgn | 16'h7E00 | 16'(man >> 13);
      return sgn | 16'h7C00;
    end
    e = int'(b[30:23]) - 127 + 15;
    if (e >= 31) return sgn | 16'h7C00;
    if (e <= 0) begin
      if (e < -10) return sgn;
      m       = {8'd0, 1'b1, man};
      sh      = 14 - e;
      h       = m >> sh;
      rem     = m & ((32'd1 << sh) - 32'd1);
      halfway = 32'd1 << (sh - 1);
    end else begin
      h       = (32'(e) << 10) | 32'(man >> 13);
      rem     = 32'(man[12:0]);
      halfway = 32'h1000;
    end
    if (rem > halfway || (rem == halfway && h[0])) h = h + 32'd1;
    return sgn | {1'b0, h[14:0]};
  endfunction

  function automatic packed_vertex_t quantize_vertex(input vertex_t v);
    packed_vertex_t r;
    r = '{default: '0};
    if (mask_q[vaq_pkg::MASK_POS])
      r.pos = {unorm16(v.pos_z, min_q[2], inv_q[2]),
               unorm16(v.pos_xy[63:32], min_q[1], inv_q[1]),
               unorm16(v.pos_xy[31:0], min_q[0], inv_q[0])};
    if (mask_q[vaq_pkg::MASK_NRM])
      r.nrm = {snorm16(v.normal_z), snorm16(v.normal_xy[63:32]),
               snorm16(v.normal_xy[31:0])};
    if (mask_q[vaq_pkg::MASK_UV0])
      r.uv0 = {half_of(v.uv_first[63:32]), half_of(v.uv_first[31:0])};
    if (mask_q[vaq_pkg::MASK_UV1])
      r.uv1 = {half_of(v.uv_second[63:32]), half_of(v.uv_second[31:0])};
    if (mask_q[vaq_pkg::MASK_TAN])
      r.tan = {snorm16(v.tangent_zw[63:32]), snorm16(v.tangent_zw[31:0]),
               snorm16(v.tangent_xy[63:32]), snorm16(v.tangent_xy[31:0])};
    r.last = v.last_vertex;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Values a quantizer tends to trip over: signed zeros, NaN, infinities,
  // the largest float, subnormals and the exact ends of the unit range.
  function automatic logic [31:0] special_f32();
    case ($urandom_range(0, 11))
      0:  return 32'd0;
      1:  return 32'h8000_0000;
      2:  return vaq_pkg::FP_QNAN;
      3:  return F32_NAN_NEG;
      4:  return F32_PINF;
      5:  return F32_NINF;
      6:  return F32_MAX;
      7:  return F32_DENORM;
      8:  return vaq_pkg::FP_ONE;
      9:  return F32_MINUS1;
      10: return F32_HALF;
      default: return {F32_MAX[31], F32_MAX[30:0]} | 32'h8000_0000;
    endcase
  endfunction

  // Mostly in-range values with random content, some raw bit patterns and
  // some special values; span scales the in-range part.
  function automatic logic [31:0] rand_f32(input real span);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      return real_to_f32((real'($urandom_range(0, 2000000)) / 1000000.0 - 1.0) * span);
    if (pick < 85) return $urandom;
    return special_f32();
  endfunction

  // UVs: exponents spread over the half-float range, its edges included.
  function automatic logic [31:0] rand_uv();
    if ($urandom_range(0, 9) < 7)
      return {1'($urandom), 8'($urandom_range(95, 145)), 23'($urandom)};
    return rand_f32(4.0);
  endfunction

  function automatic vertex_t rand_vertex(input real pos_span);
    vertex_t v;
    v.pos_xy      = {rand_f32(pos_span), rand_f32(pos_span)};
    v.pos_z       = rand_f32(pos_span);
    v.normal_xy   = {rand_f32(1.1), rand_f32(1.1)};
    v.normal_z    = rand_f32(1.1);
    v.uv_first    = {rand_uv(), rand_uv()};
    v.uv_second   = {rand_uv(), rand_uv()};
    v.tangent_xy  = {rand_f32(1.1), rand_f32(1.1)};
    v.tangent_zw  = {rand_f32(1.1), rand_f32(1.1)};
    v.last_vertex = 1'($urandom);
    return v;
  endfunction

  function automatic vertex_t splat_vertex(input logic [31:0] f, input logic last);
    vertex_t v;
    v = '{{f, f}, f, {f, f}, f, {f, f}, {f, f}, {f, f}, {f, f}, last};
    return v;
  endfunction

  // Offers one word, idling first as the current setting asks. The valid
  // stays high on return so that back-to-back words need no extra edge.
  task automatic send_vertex(input vertex_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pos_xy_i      <= v.pos_xy;
    pos_z_i       <= v.pos_z;
    normal_xy_i   <= v.normal_xy;
    normal_z_i    <= v.normal_z;
    uv_first_i    <= v.uv_first;
    uv_second_i   <= v.uv_second;
    tangent_xy_i  <= v.tangent_xy;
    tangent_zw_i  <= v.tangent_zw;
    last_vertex_i <= v.last_vertex;
    do @(posedge clk_i); while (!in_ready_o);
    packed_words_due.push_back(quantize_vertex(v));
  endtask

  // Drops valid and waits until every packed word is back and the pipeline
  // has had time to empty.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (packed_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; valid drops again before the next write.
  task automatic write_register(input vaq_pkg::cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      vaq_pkg::CFG_MASK:  mask_q   = data[4:0];
      vaq_pkg::CFG_MIN_X: min_q[0] = data;
      vaq_pkg::CFG_MIN_Y: min_q[1] = data;
      vaq_pkg::CFG_MIN_Z: min_q[2] = data;
      vaq_pkg::CFG_INV_X: inv_q[0] = data;
      vaq_pkg::CFG_INV_Y: inv_q[1] = data;
      vaq_pkg::CFG_INV_Z: inv_q[2] = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Box given by its minimum and inverse extent on all three axes.
  task automatic set_bounds(input real lo_x, input real lo_y, input real lo_z,
                            input real inv_x, input real inv_y, input real inv_z);
    drain_pipeline();
    write_register(vaq_pkg::CFG_MIN_X, real_to_f32(lo_x));
    write_register(vaq_pkg::CFG_MIN_Y, real_to_f32(lo_y));
    write_register(vaq_pkg::CFG_MIN_Z, real_to_f32(lo_z));
    write_register(vaq_pkg::CFG_INV_X, real_to_f32(inv_x));
    write_register(vaq_pkg::CFG_INV_Y, real_to_f32(inv_y));
    write_register(vaq_pkg::CFG_INV_Z, real_to_f32(inv_z));
  endtask

  task automatic set_mask(input logic [4:0] m);
    drain_pipeline();
    write_register(vaq_pkg::CFG_MASK, {27'd0, m});
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Corner values on every field at the reset settings and with a box of extents 1, 2, 4:
  // NaN, infinities, signed zeros, saturating magnitudes, subnormals, half
  // overflow and underflow, and ties of the half conversion.
  task automatic test_corner_vertices();
    vertex_t v;
    logic [31:0] corners [14];
    corners = '{32'd0, 32'h8000_0000, vaq_pkg::FP_QNAN, F32_NAN_NEG, F32_PINF, F32_NINF,
                F32_MAX, 32'hFF7F_FFFF, F32_DENORM, vaq_pkg::FP_ONE, F32_MINUS1,
                32'h4780_0000,   // 65536: half overflow
                32'h3380_1000,   // just above the smallest half subnormal
                32'h3F80_1000};  // exact tie of the half mantissa
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corners[i]) send_vertex(splat_vertex(corners[i], 1'(i)));
    set_bounds(0.0, -1.0, 2.0, 1.0, 0.5, 0.25);
    foreach (corners[i]) send_vertex(splat_vertex(corners[i], 1'(i + 1)));
    // Half-away ties of the position scaling: 0.5 of an lsb above a step.
    v = splat_vertex(F32_HALF, 1'b1);
    v.pos_xy = {real_to_f32(-1.0 + 0.5 / 65535.0 / 0.5), real_to_f32(0.5 / 65535.0)};
    send_vertex(v);
  endtask

  // Every mask setting in turn, including none and all.
  task automatic test_component_mask();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    for (int m = 0; m < 32; m++) begin
      set_mask(5'(m));
      repeat (4) send_vertex(rand_vertex(3.0));
    end
    set_mask(5'd31);
  endtask

  // Random streams under the four idling settings, each with its own box.
  task automatic test_random_streams();
    int unsigned idle_pct [4]  = '{0, 47, 0, 19};
    int unsigned stall_pct [4] = '{0, 0, 47, 19};
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_bounds(-2.0, -2.0, -2.0, 0.25, 0.25, 0.25);
        1: set_bounds(0.0, 1.0, -3.0, 0.5, 0.0, 1.0 / 6.0);
        2: set_bounds(-1.0e30, 1.0e-30, 0.0, 1.0e-30, 1.0e30, 3.0);
        default: begin
          drain_pipeline();
          write_register(vaq_pkg::CFG_MIN_X, 32'hFFFF_FFFF);
          write_register(vaq_pkg::CFG_MIN_Y, F32_PINF);
          write_register(vaq_pkg::CFG_MIN_Z, 32'h0000_0000);
          write_register(vaq_pkg::CFG_INV_X, 32'hFFFF_FFFF);
          write_register(vaq_pkg::CFG_INV_Y, 32'h0000_0000);
          write_register(vaq_pkg::CFG_INV_Z, F32_MAX);
        end
      endcase
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (200) send_vertex(rand_vertex(3.0));
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the
  // input; later the sender waits for every word to come back mid-stream.
  task automatic test_backpressure();
    set_bounds(-1.0, -1.0, -1.0, 0.5, 0.5, 0.5);
    send_idle_pct   = 0;
    recv_stall_pct  = 10;
    hold_off_cycles = 200;
    repeat (120) send_vertex(rand_vertex(1.5));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (packed_words_due.size() != 0) @(posedge clk_i);
    send_idle_pct = 30;
    repeat (120) send_vertex(rand_vertex(1.5));
  endtask

  // Output side: takes words, checks them, reports mismatches field by field and drives ready.
  always @(posedge clk_i) begin
    packed_vertex_t want;
    packed_vertex_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{pos_packed_o, normal_packed_o, uv_first_half_o, uv_second_half_o,
              tangent_packed_o, last_out_o};
      if (packed_words_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected packed word at %0t: none expected, got %h",
                   $realtime, got);
        end
      end else begin
        want = packed_words_due.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("packed word mismatch at %0t", $realtime);
            $display("  pos  exp %h got %h", want.pos, got.pos);
            $display("  nrm  exp %h got %h", want.nrm, got.nrm);
            $display("  uv0  exp %h got %h", want.uv0, got.uv0);
            $display("  uv1  exp %h got %h", want.uv1, got.uv1);
            $display("  tan  exp %h got %h", want.tan, got.tan);
            $display("  last exp %b got %b", want.last, got.last);
          end
        end
      end
    end
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i     <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = vaq_pkg::CFG_MASK;
    cfg_data_i    = 32'd0;
    in_valid_i    = 1'b0;
    pos_xy_i      = 64'd0;
    pos_z_i       = 32'd0;
    normal_xy_i   = 64'd0;
    normal_z_i    = 32'd0;
    uv_first_i    = 64'd0;
    uv_second_i   = 64'd0;
    tangent_xy_i  = 64'd0;
    tangent_zw_i  = 64'd0;
    last_vertex_i = 1'b0;
    out_ready_i   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_vertices();
    test_component_mask();
    test_random_streams();
    test_backpressure();
    drain_pipeline();

    if (mismatch_count == 0 && packed_words_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (packed_words_due.size() != 0)
        $display("%0d packed words never arrived", packed_words_due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit: well above the slowest legal run of this regression.
  initial begin
    #20ms;
    $display("timeout with %0d packed words outstanding", packed_words_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
